[sv/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

[sv/ccr_pkg.sv]
package ccr_pkg;

  localparam int CW   = 24;
  localparam int RW   = 20;
  localparam int SW   = 16;
  localparam int DW   = CW + 2;
  localparam int NW   = 2 * DW + 1;
  localparam int SQW  = DW;
  localparam int PMW  = 21;
  localparam int PW   = DW + 2;
  localparam int DNW  = DW + 1;
  localparam int DVW  = DNW + 1;
  localparam int QW   = 22;
  localparam int NUW  = DW + PMW + 3;
  localparam int EW   = CW + 2;

  localparam logic [SW-1:0] SLACK_RESET = SW'(1280);
  localparam int            ONE_Q8      = 256;

  localparam logic [1:0] CMD_CIRCLE = 2'd0;
  localparam logic [1:0] CMD_BOX    = 2'd1;
  localparam logic [1:0] CMD_PASS   = 2'd2;
  localparam logic [1:0] CMD_SPARE  = 2'd3;

  typedef enum logic [1:0] {
    FACE_LEFT,
    FACE_RIGHT,
    FACE_TOP,
    FACE_BOTTOM
  } face_e;

  typedef struct packed {
    logic [1:0]           cmd;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic [RW-1:0]        ra;
    logic [RW-1:0]        rb;
    logic [RW-1:0]        bw;
    logic [RW-1:0]        bh;
    logic signed [DW-1:0] dl;
    logic signed [DW-1:0] dr;
    logic signed [DW-1:0] dt;
    logic signed [DW-1:0] db;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] fmin;
    face_e                face;
  } front_t;

  typedef struct packed {
    logic [1:0]           cmd;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic                 pos;
    logic                 in_box;
    face_e                face;
    logic [PMW-1:0]       pen;
    logic                 sx;
    logic                 sy;
    logic [DW-1:0]        magx;
    logic [DW-1:0]        magy;
    logic [DNW-1:0]       den;
  } back_t;

endpackage

[sv/circle_collision_resolve_top.sv]
// Fully pipelined: 57 register stages, one item per cycle while the output is not stalled.
// The square root takes 26 stages and each divider 22; these set the depth.
// The whole pipe holds while a finished result is stalled at the output.
// Reset (rst_ni low, asynchronous) empties the pipe and sets overlap_slack to 5.0.
`include "assert_macros.svh"

module circle_collision_resolve_top import ccr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [SW-1:0]        cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           command_i,
  input  logic signed [CW-1:0] pos_a_x_i,
  input  logic signed [CW-1:0] pos_a_y_i,
  input  logic signed [CW-1:0] pos_b_x_i,
  input  logic signed [CW-1:0] pos_b_y_i,
  input  logic [RW-1:0]        radius_a_i,
  input  logic [RW-1:0]        radius_b_i,
  input  logic [RW-1:0]        box_width_i,
  input  logic [RW-1:0]        box_height_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [CW-1:0] new_a_x_o,
  output logic signed [CW-1:0] new_a_y_o,
  output logic signed [CW-1:0] new_b_x_o,
  output logic signed [CW-1:0] new_b_y_o,
  output logic                 moved_o
);

  function automatic logic signed [CW-1:0] sat(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] hi;
    logic signed [EW-1:0] lo;
    hi = EW'((2 ** (CW - 1)) - 1);
    lo = -hi - EW'(1);
    if (v > hi) begin
      return hi[CW-1:0];
    end else if (v < lo) begin
      return lo[CW-1:0];
    end else begin
      return v[CW-1:0];
    end
  endfunction

  logic en;
  logic [SW-1:0] slack_q;

  front_t s1_q, s2_q, s3_q, s4_q, s5_q;
  front_t s1_d, s2_d, s3_d;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [2*DW-1:0] sqx_q, sqy_q;
  logic signed [2*DW-1:0] sqx_d, sqy_d;
  logic [NW-1:0] n_q;

  front_t fs_q [SQW];
  logic [SQW-1:0] vs_q;
  logic [SQW-1:0] root;

  back_t b6_q, b7_q, b8_q, b6_d;
  logic v6_q, v7_q, v8_q;
  logic [DW+PMW-1:0] px_q, py_q;
  logic [NUW-1:0] numx_q, numy_q;
  logic [DVW-1:0] dvs_q;

  back_t bd_q [QW];
  logic [QW-1:0] vd_q;
  logic [QW-1:0] qx, qy;

  logic out_vld_q, out_moved_q;
  logic [1:0] out_cmd_q;
  logic signed [CW-1:0] out_ax_q, out_ay_q, out_bx_q, out_by_q;
  logic signed [CW-1:0] out_ax_d, out_ay_d, out_bx_d, out_by_d;
  logic out_moved_d;

  assign en         = !(out_vld_q && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slack_q <= SLACK_RESET;
    end else if (cfg_we_i) begin
      slack_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    s1_d      = '0;
    s1_d.cmd  = command_i;
    s1_d.ax   = pos_a_x_i;
    s1_d.ay   = pos_a_y_i;
    s1_d.bx   = pos_b_x_i;
    s1_d.by   = pos_b_y_i;
    s1_d.ra   = radius_a_i;
    s1_d.rb   = radius_b_i;
    s1_d.bw   = box_width_i;
    s1_d.bh   = box_height_i;
    s1_d.face = FACE_LEFT;
  end

  always_comb begin
    s2_d    = s1_q;
    s2_d.dl = DW'($signed(s1_q.ax)) - DW'($signed(s1_q.bx));
    s2_d.dt = DW'($signed(s1_q.ay)) - DW'($signed(s1_q.by));
    s2_d.dr = DW'($signed(s1_q.bx)) + DW'(s1_q.bw) - DW'($signed(s1_q.ax));
    s2_d.db = DW'($signed(s1_q.by)) + DW'(s1_q.bh) - DW'($signed(s1_q.ay));
  end

  always_comb begin
    logic signed [DW-1:0] bdx, bdy, m1, m2;
    face_e f1, f2;
    s3_d = s2_q;
    if (s2_q.dr[DW-1]) begin
      bdx = -s2_q.dr;
    end else if (s2_q.dl[DW-1]) begin
      bdx = s2_q.dl;
    end else begin
      bdx = '0;
    end
    if (s2_q.db[DW-1]) begin
      bdy = -s2_q.db;
    end else if (s2_q.dt[DW-1]) begin
      bdy = s2_q.dt;
    end else begin
      bdy = '0;
    end
    if (s2_q.cmd == CMD_BOX) begin
      s3_d.dx = bdx;
      s3_d.dy = bdy;
    end else begin
      s3_d.dx = s2_q.dl;
      s3_d.dy = s2_q.dt;
    end
    if (s2_q.dr < s2_q.dl) begin
      m1 = s2_q.dr;
      f1 = FACE_RIGHT;
    end else begin
      m1 = s2_q.dl;
      f1 = FACE_LEFT;
    end
    if (s2_q.db < s2_q.dt) begin
      m2 = s2_q.db;
      f2 = FACE_BOTTOM;
    end else begin
      m2 = s2_q.dt;
      f2 = FACE_TOP;
    end
    if (m2 < m1) begin
      s3_d.fmin = m2;
      s3_d.face = f2;
    end else begin
      s3_d.fmin = m1;
      s3_d.face = f1;
    end
  end

  assign sqx_d = s3_q.dx * s3_q.dx;
  assign sqy_d = s3_q.dy * s3_q.dy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q  <= s1_d;
      s2_q  <= s2_d;
      s3_q  <= s3_d;
      s4_q  <= s3_q;
      s5_q  <= s4_q;
      sqx_q <= $unsigned(sqx_d);
      sqy_q <= $unsigned(sqy_d);
      n_q   <= NW'(sqx_q) + NW'(sqy_q);
    end
  end

  ccr_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (n_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q <= '0;
    end else if (en) begin
      vs_q <= {vs_q[SQW-2:0], v5_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fs_q[0] <= s5_q;
      for (int i = 1; i < SQW; i++) begin
        fs_q[i] <= fs_q[i-1];
      end
    end
  end

  always_comb begin
    front_t f;
    logic zero;
    logic [SQW-1:0] d;
    logic signed [DW-1:0] vx, vy;
    logic signed [PW-1:0] pen;
    f    = fs_q[SQW-1];
    zero = (root == '0);
    d    = (zero && f.cmd == CMD_CIRCLE) ? SQW'(ONE_Q8) : root;
    vx   = (zero && f.cmd == CMD_CIRCLE) ? DW'(ONE_Q8) : f.dx;
    vy   = (zero && f.cmd == CMD_CIRCLE) ? '0 : f.dy;
    if (f.cmd == CMD_CIRCLE) begin
      pen = PW'(f.ra) + PW'(f.rb) - PW'(slack_q) - PW'(d);
    end else if (zero) begin
      pen = PW'(f.ra) - PW'(f.fmin);
    end else begin
      pen = PW'(f.ra) - PW'(root);
    end
    b6_d.cmd    = f.cmd;
    b6_d.ax     = f.ax;
    b6_d.ay     = f.ay;
    b6_d.bx     = f.bx;
    b6_d.by     = f.by;
    b6_d.pos    = !pen[PW-1] && (pen != '0) && (f.cmd == CMD_CIRCLE || f.cmd == CMD_BOX);
    b6_d.in_box = zero && (f.cmd == CMD_BOX);
    b6_d.face   = f.face;
    b6_d.pen    = pen[PMW-1:0];
    b6_d.sx     = vx[DW-1];
    b6_d.sy     = vy[DW-1];
    b6_d.magx   = vx[DW-1] ? $unsigned(-vx) : $unsigned(vx);
    b6_d.magy   = vy[DW-1] ? $unsigned(-vy) : $unsigned(vy);
    b6_d.den    = (f.cmd == CMD_CIRCLE) ? {d, 1'b0} : DNW'(root);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else if (en) begin
      v6_q <= vs_q[SQW-1];
      v7_q <= v6_q;
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b6_q   <= b6_d;
      b7_q   <= b6_q;
      b8_q   <= b7_q;
      px_q   <= (DW + PMW)'(b6_q.magx) * (DW + PMW)'(b6_q.pen);
      py_q   <= (DW + PMW)'(b6_q.magy) * (DW + PMW)'(b6_q.pen);
      numx_q <= NUW'({px_q, 1'b0}) + NUW'(b7_q.den);
      numy_q <= NUW'({py_q, 1'b0}) + NUW'(b7_q.den);
      dvs_q  <= {b7_q.den, 1'b0};
    end
  end

  ccr_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (numx_q),
    .dvs_i (dvs_q),
    .quo_o (qx)
  );

  ccr_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (numy_q),
    .dvs_i (dvs_q),
    .quo_o (qy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= '0;
    end else if (en) begin
      vd_q <= {vd_q[QW-2:0], v8_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bd_q[0] <= b8_q;
      for (int i = 1; i < QW; i++) begin
        bd_q[i] <= bd_q[i-1];
      end
    end
  end

  always_comb begin
    back_t b;
    logic signed [EW-1:0] mx, my, pe, dax, day, dbx, dby;
    b   = bd_q[QW-1];
    mx  = b.sx ? -EW'(qx) : EW'(qx);
    my  = b.sy ? -EW'(qy) : EW'(qy);
    pe  = EW'(b.pen);
    dax = '0;
    day = '0;
    dbx = '0;
    dby = '0;
    if (b.pos) begin
      if (b.cmd == CMD_CIRCLE) begin
        dax = mx;
        day = my;
        dbx = -mx;
        dby = -my;
      end else if (b.in_box) begin
        case (b.face)
          FACE_LEFT:   dax = -pe;
          FACE_RIGHT:  dax = pe;
          FACE_TOP:    day = -pe;
          FACE_BOTTOM: day = pe;
          default:     dax = '0;
        endcase
      end else begin
        dax = mx;
        day = my;
      end
    end
    out_ax_d    = sat(EW'($signed(b.ax)) + dax);
    out_ay_d    = sat(EW'($signed(b.ay)) + day);
    out_bx_d    = sat(EW'($signed(b.bx)) + dbx);
    out_by_d    = sat(EW'($signed(b.by)) + dby);
    out_moved_d = b.pos;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vd_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_ax_q    <= out_ax_d;
      out_ay_q    <= out_ay_d;
      out_bx_q    <= out_bx_d;
      out_by_q    <= out_by_d;
      out_moved_q <= out_moved_d;
      out_cmd_q   <= bd_q[QW-1].cmd;
    end
  end

  assign out_valid_o = out_vld_q;
  assign new_a_x_o   = out_ax_q;
  assign new_a_y_o   = out_ay_q;
  assign new_b_x_o   = out_bx_q;
  assign new_b_y_o   = out_by_q;
  assign moved_o     = out_moved_q;

  `ASSERT_ALWAYS(a_pass_not_moved, !(out_vld_q && out_moved_q) || !out_cmd_q[1], "pass item moved")
  `ASSERT_NEXT(a_drain_to_out, en && vd_q[QW-1], out_vld_q, "item lost at output stage")
  `ASSERT_NEXT(a_stall_holds, !en && v1_q, v1_q, "item dropped during stall")

endmodule

[sv/ccr_sqrt.sv]
module ccr_sqrt import ccr_pkg::*; (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [NW-1:0]  rad_i,
  output logic [SQW-1:0] root_o
);

  logic [NW-1:0]  rem_q  [SQW];
  logic [SQW-1:0] root_q [SQW];
  logic [NW-1:0]  rem_d  [SQW];
  logic [SQW-1:0] root_d [SQW];

  for (genvar k = 0; k < SQW; k++) begin : g_stage
    localparam int B = SQW - 1 - k;
    logic [NW-1:0]  rem_in;
    logic [SQW-1:0] root_in;
    logic [NW-1:0]  trial;

    if (k == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    always_comb begin
      trial = NW'({root_in, 1'b0} | ((SQW + 1)'(1) << B)) << B;
      if (rem_in >= trial) begin
        rem_d[k]  = rem_in - trial;
        root_d[k] = root_in | (SQW'(1) << B);
      end else begin
        rem_d[k]  = rem_in;
        root_d[k] = root_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
      end
    end
  end

  assign root_o = root_q[SQW-1];

endmodule

[sv/ccr_div.sv]
module ccr_div import ccr_pkg::*; (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [NUW-1:0] num_i,
  input  logic [DVW-1:0] dvs_i,
  output logic [QW-1:0]  quo_o
);

  logic [NUW-1:0] rem_q [QW];
  logic [DVW-1:0] dvs_q [QW];
  logic [QW-1:0]  quo_q [QW];
  logic [NUW-1:0] rem_d [QW];
  logic [QW-1:0]  quo_d [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [NUW-1:0] rem_in;
    logic [DVW-1:0] dvs_in;
    logic [QW-1:0]  quo_in;
    logic [NUW-1:0] trial;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign dvs_in = dvs_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign dvs_in = dvs_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    always_comb begin
      trial = NUW'(dvs_in) << B;
      if (rem_in >= trial) begin
        rem_d[k] = rem_in - trial;
        quo_d[k] = quo_in | (QW'(1) << B);
      end else begin
        rem_d[k] = rem_in;
        quo_d[k] = quo_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d[k];
        dvs_q[k] <= dvs_in;
        quo_q[k] <= quo_d[k];
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule
